// ----- hw/rtl/hrpt_pkg.sv -----
package hrpt_pkg;

  localparam int RES_W      = 13;
  localparam int POS_W      = 12;
  localparam int AVG_W      = 24;
  localparam int IN_DATA_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 1;

  localparam logic [RES_W-1:0] RES_RESET = RES_W'(256);
  localparam logic [POS_W-1:0] POS_MAX   = '1;
  localparam logic [AVG_W-1:0] AVG_MAX   = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

// ----- hw/rtl/hrpt_serdiv.sv -----
module hrpt_serdiv #(
  parameter int DW = 16,
  parameter int VW = 8,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [QW-1:0] quotient,
  output logic          overflow
);

  localparam int HW    = DW - QW;
  localparam int CW    = (HW > VW) ? HW : VW;
  localparam int CNT_W = $clog2(QW + 1);

  logic [VW-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [VW-1:0]    dvs_r, dvs_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;

  logic [CW-1:0]    hi_ext;
  logic [CW-1:0]    dvs_ext;
  logic             hi_ge;
  logic [VW:0]      rem_sh;
  logic [VW+1:0]    diff;
  logic             ge;

  assign hi_ext  = CW'(dividend[DW-1:QW]);
  assign dvs_ext = CW'(divisor);
  assign hi_ge   = (hi_ext >= dvs_ext);
  assign rem_sh  = {rem_r, q_r[QW-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign ge      = ~diff[VW+1];

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = hi_ge ? '0 : hi_ext[VW-1:0];
      q_nxt    = dividend[QW-1:0];
      dvs_nxt  = divisor;
      ovf_nxt  = hi_ge;
      cnt_nxt  = CNT_W'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      q_nxt    = {q_r[QW-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
    ovf_r <= ovf_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;
  assign overflow = ovf_r;

endmodule

// ----- hw/rtl/hrpt_sermul.sv -----
module hrpt_sermul #(
  parameter int AW = 16,
  parameter int BW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic [AW+BW-1:0] product
);

  localparam int PW    = AW + BW;
  localparam int CNT_W = $clog2(BW + 1);

  logic [PW-1:0]    acc_r, acc_nxt;
  logic [AW-1:0]    a_r, a_nxt;
  logic [BW-1:0]    b_r, b_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      cnt_nxt  = CNT_W'(BW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt  = {acc_r[PW-2:0], 1'b0} + (b_r[BW-1] ? PW'(a_r) : '0);
      b_nxt    = b_r << 1;
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign busy    = busy_r;
  assign product = acc_r;

endmodule

// ----- hw/rtl/hall_rotation_phase_tracker.sv -----
// An input beat is accepted only in the idle state, so no new beat is taken until the result of
// the last one is loaded into the output register. Each beat runs the bit-serial multiply
// over the tick count and then the 13-step position divider; output back-pressure stalls it too.
// Reset is synchronous and active low; it clears the tick counter, running sum, fill count
// and write slot and sets the resolution to 256. The interval memory is not cleared; the
// fill count keeps unwritten entries from ever being read.
module hall_rotation_phase_tracker
  import hrpt_pkg::*;
#(
  parameter int HISTORY_DEPTH = 50,
  parameter int TICK_WIDTH    = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] rising_edge
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [11:0] temporal_position, [35:12] average_interval
  output logic [OUT_USER_W-1:0] out_tuser,  // [0] window_full
  input  logic                  cfg_tvalid,
  output logic                  cfg_tready,
  input  logic [CFG_DATA_W-1:0] cfg_tdata   // [12:0] temporal_resolution
);

  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W  = TICK_WIDTH + FILL_W;
  localparam int RF_W   = RES_W + FILL_W;
  localparam int PROD_W = RF_W + TICK_WIDTH;
  localparam int NUM_W  = PROD_W + 2;
  localparam int DVS_W  = SUM_W + 1;
  localparam int XW     = (TICK_WIDTH > AVG_W) ? TICK_WIDTH : AVG_W;
  localparam int PAD_W  = OUT_DATA_W - AVG_W - POS_W;

  localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

  state_t state_r, state_nxt;

  logic [RES_W-1:0]      res_r;
  logic                  edge_r;
  logic [TICK_WIDTH-1:0] ticks_r, ticks_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;

  logic [TICK_WIDTH-1:0] ring [HISTORY_DEPTH];
  logic [TICK_WIDTH-1:0] ring_rd_r;
  logic [TICK_WIDTH-1:0] iv;

  logic upd_en, ring_we, unit_start, pos_start, out_load;

  logic                  mul_busy;
  logic [PROD_W-1:0]     mul_prod;
  logic                  avg_busy, avg_ovf;
  logic [TICK_WIDTH-1:0] avg_quot;
  logic                  pos_busy, pos_ovf;
  logic [RES_W-1:0]      pos_quot;

  logic [RES_W-1:0] pos_q, res_lim, pos_min;
  logic [POS_W-1:0] pos_val;
  logic [XW-1:0]    avg_x;
  logic [AVG_W-1:0] avg_val;
  logic             full_val;

  logic             out_tvalid_r;
  logic [POS_W-1:0] out_pos_r;
  logic [AVG_W-1:0] out_avg_r;
  logic             out_full_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_START;
      S_START:  state_nxt = S_MUL;
      S_MUL:    if (!mul_busy) state_nxt = S_DIV;
      S_DIV:    if (!avg_busy && !pos_busy) state_nxt = S_FINISH;
      S_FINISH: if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    upd_en     = 1'b0;
    ring_we    = 1'b0;
    unit_start = 1'b0;
    pos_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      S_IDLE:   in_tready = 1'b1;
      S_UPDATE: begin
        upd_en  = 1'b1;
        ring_we = edge_r;
      end
      S_START:  unit_start = 1'b1;
      S_MUL:    pos_start = !mul_busy;
      S_DIV:    ;
      S_FINISH: out_load = !out_tvalid_r || out_tready;
      default:  ;
    endcase
  end

  assign iv = (ticks_r == TICK_MAX) ? TICK_MAX : ticks_r + TICK_WIDTH'(1);

  always_comb begin
    ticks_nxt = ticks_r;
    sum_nxt   = sum_r;
    fill_nxt  = fill_r;
    slot_nxt  = slot_r;
    if (upd_en) begin
      if (edge_r) begin
        ticks_nxt = '0;
        if (fill_r == FILL_W'(HISTORY_DEPTH)) begin
          sum_nxt = sum_r - SUM_W'(ring_rd_r) + SUM_W'(iv);
        end else begin
          sum_nxt  = sum_r + SUM_W'(iv);
          fill_nxt = fill_r + FILL_W'(1);
        end
        slot_nxt = (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
      end else if (ticks_r != TICK_MAX) begin
        ticks_nxt = ticks_r + TICK_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[slot_r] <= iv;
    end
    ring_rd_r <= ring[slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= RES_RESET;
      ticks_r <= '0;
      sum_r   <= '0;
      fill_r  <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_tvalid) begin
        res_r <= cfg_tdata[RES_W-1:0];
      end
      ticks_r <= ticks_nxt;
      sum_r   <= sum_nxt;
      fill_r  <= fill_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      edge_r <= in_tdata[0];
    end
  end

  assign cfg_tready = 1'b1;

  hrpt_sermul #(
    .AW (RF_W),
    .BW (TICK_WIDTH)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (unit_start),
    .a       (RF_W'(res_r) * RF_W'(fill_r)),
    .b       (ticks_r),
    .busy    (mul_busy),
    .product (mul_prod)
  );

  hrpt_serdiv #(
    .DW (SUM_W),
    .VW (FILL_W),
    .QW (TICK_WIDTH)
  ) u_avg_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (unit_start),
    .dividend (sum_r),
    .divisor  (fill_r),
    .busy     (avg_busy),
    .quotient (avg_quot),
    .overflow (avg_ovf)
  );

  hrpt_serdiv #(
    .DW (NUM_W),
    .VW (DVS_W),
    .QW (RES_W)
  ) u_pos_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (pos_start),
    .dividend (NUM_W'({mul_prod, 1'b0}) + NUM_W'(sum_r)),
    .divisor  ({sum_r, 1'b0}),
    .busy     (pos_busy),
    .quotient (pos_quot),
    .overflow (pos_ovf)
  );

  always_comb begin
    pos_q   = pos_ovf ? '1 : pos_quot;
    res_lim = res_r - RES_W'(1);
    pos_min = (pos_q > res_lim) ? res_lim : pos_q;
    pos_val = (pos_min > RES_W'(POS_MAX)) ? POS_MAX : pos_min[POS_W-1:0];
    if (fill_r == '0 || sum_r == '0 || res_r == '0) begin
      pos_val = '0;
    end
    avg_x = XW'(avg_quot);
    if (fill_r == '0 || avg_ovf) begin
      avg_val = '0;
    end else if (avg_x > XW'(AVG_MAX)) begin
      avg_val = AVG_MAX;
    end else begin
      avg_val = avg_x[AVG_W-1:0];
    end
    full_val = (fill_r == FILL_W'(HISTORY_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_r  <= pos_val;
      out_avg_r  <= avg_val;
      out_full_r <= full_val;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_avg_r, out_pos_r};
  assign out_tuser  = out_full_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HISTORY_DEPTH))
    else $error("fill count above window depth");

  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !(mul_busy || avg_busy || pos_busy))
    else $error("input beat taken while arithmetic units busy");

  a_edge_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE && edge_r) |=> (ticks_r == '0))
    else $error("tick counter not restarted on edge");
`endif

endmodule

// ----- tb/hall_rotation_phase_tracker_tb.sv -----
`timescale 1ns / 100ps

module hall_rotation_phase_tracker_tb;
  import hrpt_pkg::*;

  localparam int WINDOW_DEPTH = 50;
  localparam int RESULT_SLOTS = 64;
  localparam longint unsigned TICK_LIMIT = (64'd1 << 24) - 1;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [AVG_W-1:0] mean_interval;
    logic             window_full;
  } tick_result_t;

  class tach_scoreboard;
    logic [AVG_W-1:0] interval_hist [WINDOW_DEPTH];
    longint unsigned  interval_total;
    int unsigned      filled;
    int unsigned      next_slot;
    longint unsigned  since_edge;
    logic [RES_W-1:0] resolution;
    tick_result_t     expected_buf [RESULT_SLOTS];
    int unsigned      head_idx;
    int unsigned      tail_idx;
    int unsigned      held;
    int unsigned      mismatches;
    int unsigned      results_seen;
    int unsigned      ticks_sent;
    int unsigned      edges_sent;
    int unsigned      full_results;
    int unsigned      clamped_results;
    int unsigned      settings_used;

    function new();
      interval_total = 0;
      filled = 0;
      next_slot = 0;
      since_edge = 0;
      resolution = RES_RESET;
      head_idx = 0;
      tail_idx = 0;
      held = 0;
      mismatches = 0;
      results_seen = 0;
      ticks_sent = 0;
      edges_sent = 0;
      full_results = 0;
      clamped_results = 0;
      settings_used = 1;
    endfunction

    function void set_resolution(logic [RES_W-1:0] value);
      resolution = value;
      settings_used++;
    endfunction

    function int unsigned pending_count();
      return held;
    endfunction

    function void note_tick(bit rise);
      longint unsigned iv;
      longint unsigned num;
      longint unsigned pos;
      longint unsigned avg;
      longint unsigned res;
      tick_result_t    exp_res;
      ticks_sent++;
      if (rise) begin
        edges_sent++;
        iv = since_edge + 1;
        if (iv > TICK_LIMIT) iv = TICK_LIMIT;
        if (filled >= WINDOW_DEPTH) interval_total -= interval_hist[next_slot];
        else filled++;
        interval_hist[next_slot] = iv[AVG_W-1:0];
        interval_total += iv;
        next_slot = (next_slot + 1 == WINDOW_DEPTH) ? 0 : next_slot + 1;
        since_edge = 0;
      end else if (since_edge < TICK_LIMIT) begin
        since_edge++;
      end
      pos = 0;
      avg = 0;
      res = resolution;
      if (filled > 0) begin
        avg = interval_total / filled;
        if (avg > AVG_MAX) avg = AVG_MAX;
        if (interval_total != 0 && res != 0) begin
          num = res * since_edge * filled;
          pos = (2 * num + interval_total) / (2 * interval_total);
          if (pos > res - 1) begin
            pos = res - 1;
            clamped_results++;
          end
          if (pos > POS_MAX) pos = POS_MAX;
        end
      end
      exp_res.position      = pos[POS_W-1:0];
      exp_res.mean_interval = avg[AVG_W-1:0];
      exp_res.window_full   = (filled == WINDOW_DEPTH);
      expected_buf[tail_idx] = exp_res;
      tail_idx = (tail_idx + 1) % RESULT_SLOTS;
      held++;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [POS_W-1:0] position, logic [AVG_W-1:0] mean_interval,
                      logic window_full);
      tick_result_t exp_res;
      results_seen++;
      if (held == 0) begin
        report_mismatch($sformatf("unexpected result beat pos=%0d avg=%0d full=%0b",
                                  position, mean_interval, window_full));
      end else begin
        exp_res = expected_buf[head_idx];
        head_idx = (head_idx + 1) % RESULT_SLOTS;
        held--;
        if (exp_res.window_full) full_results++;
        if (position !== exp_res.position)
          report_mismatch($sformatf("result %0d temporal_position got %0d expected %0d",
                                    results_seen, position, exp_res.position));
        if (mean_interval !== exp_res.mean_interval)
          report_mismatch($sformatf("result %0d average_interval got %0d expected %0d",
                                    results_seen, mean_interval, exp_res.mean_interval));
        if (window_full !== exp_res.window_full)
          report_mismatch($sformatf("result %0d window_full got %0b expected %0b",
                                    results_seen, window_full, exp_res.window_full));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // [0] rising_edge
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [11:0] temporal_position, [35:12] average_interval
  logic [OUT_USER_W-1:0] out_tuser;        // [0] window_full
  logic                  cfg_tvalid = 1'b0;
  logic                  cfg_tready;
  logic [CFG_DATA_W-1:0] cfg_tdata = '0;   // [12:0] temporal_resolution

  tach_scoreboard sb = new();
  bit             calm_mode = 1'b0;
  int unsigned    stall_left = 0;

  hall_rotation_phase_tracker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  always #6 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 50);
    return $urandom_range(100, 300);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm_mode && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 40);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[POS_W-1:0], out_tdata[POS_W+AVG_W-1:POS_W], out_tuser[0]);
  end

  task automatic send_tick(bit rise);
    int unsigned gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-1){1'b0}}, rise};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(rise);
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_until_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  task automatic write_resolution(logic [RES_W-1:0] value);
    wait_until_idle();
    @(negedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {{(CFG_DATA_W-RES_W){1'b0}}, value};
    do @(posedge clk); while (!cfg_tready);
    sb.set_resolution(value);
    @(negedge clk);
    cfg_tvalid <= 1'b0;
  endtask

  // Steady rotation with occasional jitter, slowdowns and random edge noise.
  task automatic run_rotation(int unsigned n_ticks);
    int unsigned period;
    int unsigned since;
    int unsigned k;
    bit          rise;
    period = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    since = 0;
    for (k = 0; k < n_ticks; k++) begin
      since++;
      if ($urandom_range(0, 9) == 0) begin
        rise = $urandom_range(0, 1);
      end else begin
        rise = (since >= period);
        if (rise && $urandom_range(0, 3) == 0)
          period = (period > 1 && $urandom_range(0, 1)) ? period - 1 : period + 1;
      end
      if (rise) since = 0;
      send_tick(rise);
    end
  endtask

  initial begin
    logic [RES_W-1:0] res_plan [9];
    int unsigned      p;
    res_plan = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd4097, 13'd2,
                 13'($urandom_range(1, 4096)), 13'($urandom_range(3, 4095)),
                 13'($urandom_range(0, 8191))};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty window, first edge, overrun past the mean, back-to-back edges, resolutions 0, 8191, 4096.
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    write_resolution(13'd0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    write_resolution(13'd8191);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    write_resolution(13'd4096);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);

    for (p = 0; p < 9; p++) begin
      write_resolution(res_plan[p]);
      calm_mode = (p % 4 == 2);
      run_rotation(75);
    end
    calm_mode = 1'b0;

    wait_until_idle();
    repeat (60) @(posedge clk);
    $display("Covered %0d ticks with %0d hall edges across %0d resolution settings.",
             sb.ticks_sent, sb.edges_sent, sb.settings_used);
    $display("Checked %0d results: %0d with a full window, %0d with a clamped position.",
             sb.results_seen, sb.full_results, sb.clamped_results);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("hall_rotation_phase_tracker test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_count());
      $display("hall_rotation_phase_tracker test failed");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("Timeout with %0d results still outstanding.", sb.pending_count());
    $display("hall_rotation_phase_tracker test failed");
    $finish;
  end

endmodule
